FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: design/osm_pkg.sv
package osm_pkg;

   // Grid geometry
   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int MEM_DEPTH  = 1 << ADDR_W;

   // Field and register widths
   localparam int SIZE_W     = 6;
   localparam int KIND_W     = 2;
   localparam int RND_W      = 8;
   localparam int DIR_W      = 3;
   localparam int CSR_IDX_W  = 1;

   // Size after reset
   localparam int RESET_WIDTH  = 5;
   localparam int RESET_HEIGHT = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAZE_HEIGHT = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_STEP  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_BUILD = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [DIR_W-1:0] {
      PTR_ROOT  = 3'd0,
      PTR_RIGHT = 3'd1,
      PTR_LEFT  = 3'd2,
      PTR_UP    = 3'd3,
      PTR_DOWN  = 3'd4
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESULT,
      ST_BUILD,
      ST_CLEAR
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start_item;   // step, read or no-op transfer taken
      logic start_build;  // rebuild transfer taken
      logic sweep;        // write one grid entry of the sweep
      logic finish;       // second half of an item
      logic load_rsp;     // load the result register
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sweep_last;
   } ctl_status_type;

endpackage

FILE: design/osm_controller.sv
module osm_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [osm_pkg::KIND_W-1:0]   req_kind,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output osm_pkg::ctl_cmd_type         cmd,
   input  osm_pkg::ctl_status_type      status
);
   import osm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // Result slot can take a new result this cycle
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (kind_type'(req_kind) == KIND_BUILD) begin
                  cmd.start_build = 1'b1;
                  state_in        = ST_BUILD;
               end else begin
                  cmd.start_item = 1'b1;
                  state_in       = ST_RESULT;
               end
            end
         end
         ST_RESULT: begin
            // root write repeats harmlessly while the slot is full
            cmd.finish = 1'b1;
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BUILD: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/osm_datapath.sv
module osm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  osm_pkg::ctl_cmd_type          cmd,
   output osm_pkg::ctl_status_type       status,
   input  logic                          csr_write_enable,
   input  logic [osm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [osm_pkg::SIZE_W-1:0]    csr_data,
   input  logic [osm_pkg::KIND_W-1:0]    req_kind,
   input  logic [osm_pkg::RND_W-1:0]     req_random_value,
   input  logic [osm_pkg::COL_W-1:0]     req_cell_column,
   input  logic [osm_pkg::ROW_W-1:0]     req_cell_row,
   output logic [osm_pkg::DIR_W-1:0]     rsp_cell_direction,
   output logic [osm_pkg::COL_W-1:0]     rsp_root_column,
   output logic [osm_pkg::ROW_W-1:0]     rsp_root_row,
   output logic                          rsp_step_error
);
   import osm_pkg::*;

   // Size registers: 0 stored as 1, above maximum stored as maximum
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      if (v == '0) begin
         return SIZE_W'(1);
      end else if (v > maxv) begin
         return maxv;
      end
      return v;
   endfunction

   // Residue mod 3: base-4 digit sum, since 4 is 1 mod 3
   function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      t = 3'(s[1:0]) + 3'(s[3:2]);
      if (t >= 3'd6) begin
         return 2'd0;
      end else if (t >= 3'd3) begin
         return 2'(t - 3'd3);
      end
      return t[1:0];
   endfunction

   kind_type            req_kind_t;
   logic [SIZE_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [SIZE_W-1:0]   sweep_w_ff, sweep_w_in, sweep_h_ff, sweep_h_in;
   logic [ADDR_W-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic [COL_W-1:0]    root_col_ff, root_col_in;
   logic [ROW_W-1:0]    root_row_ff, root_row_in;
   kind_type            kind_ff, kind_in;
   logic                in_grid_ff, in_grid_in;
   logic                step_ok_ff, step_ok_in;
   dir_type             rd_data_ff;
   logic [DIR_W-1:0]    rsp_dir_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_err_ff;

   logic [3:0]          legal;
   logic [2:0]          move_cnt;
   logic [1:0]          pick, seen, chosen;
   dir_type             step_dir;
   logic [COL_W-1:0]    step_col;
   logic [ROW_W-1:0]    step_row;
   logic                step_go;

   logic [COL_W-1:0]    sw_col;
   logic [ROW_W-1:0]    sw_row;
   dir_type             sw_data;

   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   dir_type             wr_data;
   dir_type             grid_mem [MEM_DEPTH];

   assign req_kind_t = kind_type'(req_kind);

   // Legal moves of the root, in the order right, left, up, down
   assign legal[0] = (SIZE_W'(root_col_ff) + SIZE_W'(1)) < width_ff;
   assign legal[1] = root_col_ff != '0;
   assign legal[2] = root_row_ff != '0;
   assign legal[3] = (SIZE_W'(root_row_ff) + SIZE_W'(1)) < height_ff;
   assign move_cnt = 3'(legal[0]) + 3'(legal[1]) + 3'(legal[2]) + 3'(legal[3]);

   // Random value reduced mod the move count
   always_comb begin
      unique case (move_cnt)
         3'd4:    pick = req_random_value[1:0];
         3'd3:    pick = mod3(req_random_value);
         3'd2:    pick = {1'b0, req_random_value[0]};
         default: pick = 2'd0;
      endcase
   end

   // Pick the chosen legal move and the neighbour it leads to
   always_comb begin
      seen   = 2'd0;
      chosen = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (legal[i]) begin
            if (seen == pick) begin
               chosen = 2'(i);
            end
            seen = seen + 2'd1;
         end
      end
      step_dir = dir_type'(3'(chosen) + 3'd1);
      step_col = root_col_ff;
      step_row = root_row_ff;
      unique case (step_dir)
         PTR_RIGHT: step_col = root_col_ff + COL_W'(1);
         PTR_LEFT:  step_col = root_col_ff - COL_W'(1);
         PTR_UP:    step_row = root_row_ff - ROW_W'(1);
         PTR_DOWN:  step_row = root_row_ff + ROW_W'(1);
         default:   step_col = root_col_ff;
      endcase
   end

   assign step_go = cmd.start_item && (req_kind_t == KIND_STEP) && (move_cnt != 3'd0);

   // Perfect-maze value of the entry under the sweep counter
   assign sw_col = sweep_cnt_ff[COL_W-1:0];
   assign sw_row = sweep_cnt_ff[ADDR_W-1:COL_W];
   always_comb begin
      sw_data = PTR_ROOT;
      if (SIZE_W'(sw_col) < sweep_w_ff && SIZE_W'(sw_row) < sweep_h_ff) begin
         if (SIZE_W'(sw_col) + SIZE_W'(1) == sweep_w_ff) begin
            sw_data = (SIZE_W'(sw_row) + SIZE_W'(1) == sweep_h_ff) ? PTR_ROOT : PTR_DOWN;
         end else begin
            sw_data = PTR_RIGHT;
         end
      end
   end

   assign status.sweep_last = &sweep_cnt_ff;

   // Grid write port: sweep, old root on a step, new root on finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {root_row_ff, root_col_ff};
      wr_data = PTR_ROOT;
      priority if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = sw_data;
      end else if (step_go) begin
         wr_en   = 1'b1;
         wr_data = step_dir;
      end else if (cmd.finish && step_ok_ff) begin
         wr_en   = 1'b1;
      end
   end

   assign rd_en   = cmd.start_item && (req_kind_t == KIND_READ);
   assign rd_addr = {req_cell_row, req_cell_column};

   // Grid memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // Next values of the control registers
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      sweep_w_in   = sweep_w_ff;
      sweep_h_in   = sweep_h_ff;
      sweep_cnt_in = sweep_cnt_ff;
      root_col_in  = root_col_ff;
      root_row_in  = root_row_ff;
      kind_in      = kind_ff;
      in_grid_in   = in_grid_ff;
      step_ok_in   = step_ok_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAZE_WIDTH:  width_in  = clamp_size(csr_data, SIZE_W'(MAX_WIDTH));
            CSR_MAZE_HEIGHT: height_in = clamp_size(csr_data, SIZE_W'(MAX_HEIGHT));
            default:         width_in  = width_ff;
         endcase
      end

      if (cmd.start_item) begin
         kind_in    = req_kind_t;
         in_grid_in = (SIZE_W'(req_cell_column) < width_ff) &&
                      (SIZE_W'(req_cell_row) < height_ff);
         step_ok_in = step_go;
         if (step_go) begin
            root_col_in = step_col;
            root_row_in = step_row;
         end
      end

      if (cmd.start_build) begin
         kind_in     = KIND_BUILD;
         in_grid_in  = 1'b0;
         step_ok_in  = 1'b0;
         sweep_w_in  = width_ff;
         sweep_h_in  = height_ff;
         root_col_in = COL_W'(width_ff - SIZE_W'(1));
         root_row_in = ROW_W'(height_ff - SIZE_W'(1));
      end

      if (cmd.sweep) begin
         sweep_cnt_in = sweep_cnt_ff + ADDR_W'(1);
      end
   end

   // Control registers; reset loads the reset size and root of the maze
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_W'(RESET_WIDTH);
         height_ff    <= SIZE_W'(RESET_HEIGHT);
         sweep_w_ff   <= SIZE_W'(RESET_WIDTH);
         sweep_h_ff   <= SIZE_W'(RESET_HEIGHT);
         sweep_cnt_ff <= '0;
         root_col_ff  <= COL_W'(RESET_WIDTH - 1);
         root_row_ff  <= ROW_W'(RESET_HEIGHT - 1);
         kind_ff      <= KIND_NOP;
         in_grid_ff   <= 1'b0;
         step_ok_ff   <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         sweep_w_ff   <= sweep_w_in;
         sweep_h_ff   <= sweep_h_in;
         sweep_cnt_ff <= sweep_cnt_in;
         root_col_ff  <= root_col_in;
         root_row_ff  <= root_row_in;
         kind_ff      <= kind_in;
         in_grid_ff   <= in_grid_in;
         step_ok_ff   <= step_ok_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_dir_ff <= (kind_ff == KIND_READ && in_grid_ff) ? rd_data_ff : PTR_ROOT;
         rsp_col_ff <= root_col_ff;
         rsp_row_ff <= root_row_ff;
         rsp_err_ff <= (kind_ff == KIND_STEP) && !step_ok_ff;
      end
   end

   assign rsp_cell_direction = rsp_dir_ff;
   assign rsp_root_column    = rsp_col_ff;
   assign rsp_root_row       = rsp_row_ff;
   assign rsp_step_error     = rsp_err_ff;

endmodule

FILE: design/origin_shift_maze_unit.sv
// Step, read and no-op: the transfer enters the result state, which loads the result
// register once the slot is free; the next item waits for that. A step writes old and new
// root on the single grid port. Rebuild: one grid entry written per cycle over all 1024
// entries. Reset (synchronous, active high): a clearing pass over every entry lays the 5x5
// perfect maze; no input is taken until it ends, configuration writes are taken throughout.
`include "assert_macros.svh"

module origin_shift_maze_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [osm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [osm_pkg::SIZE_W-1:0]    csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [osm_pkg::KIND_W-1:0]    req_kind,
   input  logic [osm_pkg::RND_W-1:0]     req_random_value,
   input  logic [osm_pkg::COL_W-1:0]     req_cell_column,
   input  logic [osm_pkg::ROW_W-1:0]     req_cell_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [osm_pkg::DIR_W-1:0]     rsp_cell_direction,
   output logic [osm_pkg::COL_W-1:0]     rsp_root_column,
   output logic [osm_pkg::ROW_W-1:0]     rsp_root_row,
   output logic                          rsp_step_error
);
   import osm_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Sequencer
   osm_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Grid, root and size registers
   osm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_kind           (req_kind),
      .req_random_value   (req_random_value),
      .req_cell_column    (req_cell_column),
      .req_cell_row       (req_cell_row),
      .rsp_cell_direction (rsp_cell_direction),
      .rsp_root_column    (rsp_root_column),
      .rsp_root_row       (rsp_root_row),
      .rsp_step_error     (rsp_step_error)
   );

   // Checks
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready && !rsp_valid)
   `ASSERT_IMPLIES(a_err_no_cell, clock, reset, rsp_valid && rsp_step_error, rsp_cell_direction == PTR_ROOT)

endmodule
